// File: rtl/core/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants for the bitmap slot pool: request kinds,
// register indexes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package bsp_pkg;

	// Parameter defaults.
	localparam int SLOT_COUNT_DEF  = 64;
	localparam int USAGE_WIDTH_DEF = 16;
	localparam int GEN_WIDTH_DEF   = 32;
	localparam int SLOT_IDX_W_DEF  = 6;
	localparam int ENTRY_W_DEF     = GEN_WIDTH_DEF + USAGE_WIDTH_DEF;

	// Fixed field widths of the request and result ports.
	localparam int KIND_W      = 3;
	localparam int SLOT_W      = 6;
	localparam int COUNT_W     = 7;
	localparam int OUT_USAGE_W = 16;
	localparam int OUT_GEN_W   = 32;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int POOL_SIZE_W = 7;
	localparam logic [POOL_SIZE_W-1:0] POOL_SIZE_RST = 7'd64;

	// Register indexes, taken from address bit 2.
	localparam logic REG_POOL_SIZE    = 1'b0;
	localparam logic REG_POOL_ENABLED = 1'b1;

	// Request kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 3'd0,
		KIND_FREE    = 3'd1,
		KIND_ACQUIRE = 3'd2,
		KIND_RELEASE = 3'd3,
		KIND_FLUSH   = 3'd4,
		KIND_QUERY   = 3'd5
	} kind_t;

endpackage

// File: rtl/core/bitmap_slot_pool_with_refcount.sv
// Result path: a request accepted at a clock edge is held in vld_s1, and its result,
// marked by done, is then registered in done_q.
// Request flow: no new request is accepted while busy is high; busy covers the cycle in which the
// entry memory read returns and the modified entry is written back.
// Reset clears the bitmap, stale marks, counters, generation and entry valid bits
// at once; no request is blocked after reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
// bitmap_slot_pool_with_refcount
// Slot pool with an allocation bitmap, per-slot usage counters, stale marks
// and slot generations, plus a global generation raised by flush.
// ----------------------------------------------------------------------------
module bitmap_slot_pool_with_refcount #(
	parameter int SLOT_COUNT  = bsp_pkg::SLOT_COUNT_DEF,
	parameter int USAGE_WIDTH = bsp_pkg::USAGE_WIDTH_DEF,
	parameter int GEN_WIDTH   = bsp_pkg::GEN_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel
	input  logic                           start,
	output logic                           busy,
	input  logic [bsp_pkg::KIND_W-1:0]     kind,
	input  logic [bsp_pkg::SLOT_W-1:0]     slot,
	// Result channel
	output logic                           done,
	output logic                           ok,
	output logic [bsp_pkg::SLOT_W-1:0]     slot_out,
	output logic                           is_taken,
	output logic [bsp_pkg::COUNT_W-1:0]    taken_count,
	output logic [bsp_pkg::OUT_USAGE_W-1:0] usage,
	output logic                           stale,
	output logic [bsp_pkg::OUT_GEN_W-1:0]  generation_out,
	output logic                           recycled,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bsp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bsp_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);

	import bsp_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ENT_W = GEN_WIDTH + USAGE_WIDTH;
	localparam logic [USAGE_WIDTH-1:0] USAGE_MAX = '1;
	localparam logic [COUNT_W-1:0] SLOT_LIMIT = COUNT_W'(SLOT_COUNT);

	// Configuration registers
	logic [POOL_SIZE_W-1:0] pool_size_q;
	logic                   pool_enabled_q;
	logic [COUNT_W-1:0]     act_size;

	// Pool state
	logic [SLOT_COUNT-1:0]  taken_q, taken_n;
	logic [SLOT_COUNT-1:0]  stale_q, stale_n;
	logic [GEN_WIDTH-1:0]   gen_q, gen_n;
	logic [COUNT_W-1:0]     count_q, count_n;

	// Request intake
	logic                   accept;
	logic [SLOT_W-1:0]      grant;
	logic                   found;
	logic [SLOT_W-1:0]      req_slot;
	logic                   vld_s1;
	logic [KIND_W-1:0]      kind_s1;
	logic [SLOT_W-1:0]      slot_s1;
	logic                   found_s1;

	// Entry memory access
	logic [ENT_W-1:0]       rd_data;
	logic [USAGE_WIDTH-1:0] usage_rd;
	logic [GEN_WIDTH-1:0]   gen_rd;
	logic                   wr_en;
	logic [GEN_WIDTH-1:0]   wr_gen;
	logic [USAGE_WIDTH-1:0] usage_n;

	// Second stage decode and result values
	logic [IDX_W-1:0]       idx_s1;
	logic                   in_rng_s1;
	logic                   valid_s1;
	logic                   ok_n;
	logic                   recycled_n;
	logic [OUT_GEN_W-1:0]   gen_out_n;

	// Result registers
	logic                   done_q;
	logic                   ok_q;
	logic [SLOT_W-1:0]      slot_out_q;
	logic                   is_taken_q;
	logic [OUT_USAGE_W-1:0] usage_q;
	logic                   stale_out_q;
	logic [OUT_GEN_W-1:0]   gen_out_q;
	logic                   recycled_q;

	// Register writes complete in the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q    <= POOL_SIZE_RST;
			pool_enabled_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_POOL_SIZE:    pool_size_q    <= pwdata[POOL_SIZE_W-1:0];
				REG_POOL_ENABLED: pool_enabled_q <= pwdata[0];
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (paddr[2])
			REG_POOL_SIZE:    prdata = APB_DATA_W'(pool_size_q);
			REG_POOL_ENABLED: prdata = APB_DATA_W'(pool_enabled_q);
		endcase
	end

	assign pready = 1'b1;

	// Number of active slots: zero while disabled, capped at the slot count.
	always_comb begin
		if (!pool_enabled_q) begin
			act_size = '0;
		end else if (pool_size_q > SLOT_LIMIT) begin
			act_size = SLOT_LIMIT;
		end else begin
			act_size = pool_size_q;
		end
	end

	// Lowest free active slot, found while the request is offered.
	always_comb begin
		grant = '0;
		found = 1'b0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!taken_q[i] && (COUNT_W'(i) < act_size)) begin
				grant = SLOT_W'(i);
				found = 1'b1;
			end
		end
	end

	assign accept   = start && !vld_s1;
	assign busy     = vld_s1;
	assign req_slot = ((kind == KIND_ALLOC) && found) ? grant : slot;

	// First stage: hold the request while the entry read is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			slot_s1  <= req_slot;
			found_s1 <= (kind == KIND_ALLOC) && found;
		end
	end

	// Entry memory: generation and usage counter of each slot.
	bsp_slot_store #(
		.DEPTH  (SLOT_COUNT),
		.IDX_W  (IDX_W),
		.DATA_W (ENT_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (req_slot[IDX_W-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data ({wr_gen, usage_n})
	);

	assign usage_rd  = rd_data[USAGE_WIDTH-1:0];
	assign gen_rd    = rd_data[ENT_W-1:USAGE_WIDTH];
	assign idx_s1    = slot_s1[IDX_W-1:0];
	assign in_rng_s1 = {1'b0, slot_s1} < SLOT_LIMIT;
	assign valid_s1  = {1'b0, slot_s1} < act_size;

	// Second stage: modify the entry and the pool state for the request.
	always_comb begin
		taken_n    = taken_q;
		stale_n    = stale_q;
		gen_n      = gen_q;
		count_n    = count_q;
		usage_n    = usage_rd;
		wr_gen     = gen_rd;
		wr_en      = 1'b0;
		ok_n       = 1'b0;
		recycled_n = 1'b0;
		gen_out_n  = OUT_GEN_W'(gen_q);
		if (vld_s1) begin
			unique case (kind_s1)
				KIND_ALLOC: begin
					if (found_s1) begin
						taken_n[idx_s1] = 1'b1;
						count_n         = count_q + COUNT_W'(1);
						ok_n            = 1'b1;
					end
				end
				KIND_FREE: begin
					if (valid_s1) begin
						if (taken_q[idx_s1]) begin
							count_n = count_q - COUNT_W'(1);
						end
						taken_n[idx_s1] = 1'b0;
						ok_n            = 1'b1;
					end
				end
				KIND_ACQUIRE: begin
					if (valid_s1) begin
						if (usage_rd != USAGE_MAX) begin
							usage_n = usage_rd + USAGE_WIDTH'(1);
						end
						wr_en = 1'b1;
						ok_n  = 1'b1;
					end
				end
				KIND_RELEASE: begin
					if (valid_s1) begin
						if (usage_rd != '0) begin
							usage_n = usage_rd - USAGE_WIDTH'(1);
						end
						// A stale slot whose last user leaves is recycled.
						if ((usage_rd == USAGE_WIDTH'(1)) && stale_q[idx_s1]) begin
							stale_n[idx_s1] = 1'b0;
							wr_gen          = gen_q;
							recycled_n      = 1'b1;
						end
						wr_en = 1'b1;
						ok_n  = 1'b1;
					end
				end
				KIND_FLUSH: begin
					if (pool_enabled_q) begin
						gen_n = gen_q + GEN_WIDTH'(1);
						for (int i = 0; i < SLOT_COUNT; i++) begin
							if (COUNT_W'(i) < act_size) begin
								stale_n[i] = 1'b1;
							end
						end
						gen_out_n = OUT_GEN_W'(gen_n);
						ok_n      = 1'b1;
					end else begin
						gen_out_n = '0;
					end
				end
				KIND_QUERY: begin
					ok_n = valid_s1;
				end
				default: begin
				end
			endcase
		end
	end

	// Pool state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			stale_q <= '0;
			gen_q   <= '0;
			count_q <= '0;
		end else begin
			taken_q <= taken_n;
			stale_q <= stale_n;
			gen_q   <= gen_n;
			count_q <= count_n;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	// Result payload; slot fields read as zero beyond the slot count.
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			ok_q        <= ok_n;
			slot_out_q  <= slot_s1;
			is_taken_q  <= in_rng_s1 && taken_n[idx_s1];
			usage_q     <= in_rng_s1 ? OUT_USAGE_W'(usage_n) : '0;
			stale_out_q <= in_rng_s1 && stale_n[idx_s1];
			gen_out_q   <= gen_out_n;
			recycled_q  <= recycled_n;
		end
	end

	assign done           = done_q;
	assign ok             = ok_q;
	assign slot_out       = slot_out_q;
	assign is_taken       = is_taken_q;
	assign taken_count    = count_q;
	assign usage          = usage_q;
	assign stale          = stale_out_q;
	assign generation_out = gen_out_q;
	assign recycled       = recycled_q;

`ifndef SYNTHESIS
	// The running count always matches the bitmap.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == COUNT_W'($countones(taken_q)))
		else $error("taken count differs from bitmap population");

	// A granted slot was free when it was granted.
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && found_s1) |-> !taken_q[idx_s1])
		else $error("alloc granted a slot that was already taken");

	// A result follows every second-stage request and nothing else.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(vld_s1))
		else $error("result strobe without a request in flight");

	// An enabled flush advances the global generation by one.
	a_flush_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (kind_s1 == KIND_FLUSH) && pool_enabled_q)
		|=> (gen_q == GEN_WIDTH'($past(gen_q) + GEN_WIDTH'(1))))
		else $error("flush did not advance the generation");
`endif

endmodule

// File: rtl/core/bsp_slot_store.sv
// ----------------------------------------------------------------------------
// bsp_slot_store
// Per-slot entry memory with one read and one write port and a registered
// read. A valid bit per entry makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
module bsp_slot_store #(
	parameter int DEPTH  = bsp_pkg::SLOT_COUNT_DEF,
	parameter int IDX_W  = bsp_pkg::SLOT_IDX_W_DEF,
	parameter int DATA_W = bsp_pkg::ENTRY_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  ent_vld_q;
	logic [DATA_W-1:0] rd_q;
	logic              rd_vld_q;

	// Storage array and registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// Entry valid bits stand in for the all-zero reset of the array.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= ent_vld_q[rd_addr];
			end
		end
	end

	// An entry that was never written reads as zero.
	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule
